// ===== rtl/core/bda_pkg.sv =====
// Shared types and codes of the deadlock-avoidance engine.
package bda_pkg;

    localparam logic [2:0] MODE_WRITE   = 3'd0;
    localparam logic [2:0] MODE_TOTAL   = 3'd1;
    localparam logic [2:0] MODE_FIND    = 3'd2;
    localparam logic [2:0] MODE_ORDER   = 3'd3;
    localparam logic [2:0] MODE_REQUEST = 3'd4;

    localparam logic [1:0] KIND_ORDER   = 2'd0;
    localparam logic [1:0] KIND_CHECK   = 2'd1;
    localparam logic [1:0] KIND_REQUEST = 2'd2;

    localparam logic [3:0] CFG_NUM_PROCS = 4'd0;
    localparam logic [3:0] CFG_NUM_RES   = 4'd1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  proc_id;
        logic [2:0]  res_id;
        logic [15:0] amount;
        logic [15:0] max_claim;
        logic        last;
    } bda_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] proc_id_out;
        logic       ok;
        logic       last_out;
    } bda_result_t;

    typedef struct packed {
        logic [3:0] index;
        logic [7:0] value;
    } bda_cfg_t;

endpackage

// ===== rtl/core/bda_stream_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface bda_stream_if #(parameter type PAYLOAD_T = logic) ();
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/bda_table.sv =====
// Allocation and need table memory with per-entry valid bits that read as zero.
module bda_table #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 33
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic                                  we,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [WIDTH-1:0] rd_reg;
    logic             rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[addr];
        end
    end

    assign rdata = rd_valid_reg ? rd_reg : '0;
endmodule

// ===== rtl/core/bankers_deadlock_avoider.sv =====
// Top level: sequencer and shared compare/add unit of the deadlock-avoidance engine.
// An entry write reads, then rewrites its element; an order element tests one process row.
// A request is checked against need and availability, then applied, before a safety search.
// The safety search visits table elements one at a time through the single memory port,
// up to num_procs passes of num_procs rows, then emits one result per cycle unless stalled.
// Reset clears tables (valid bits), avail/total/request and flags; num_procs 16, num_res 8.
module bankers_deadlock_avoider #(
    parameter int MAX_PROCS = 16,
    parameter int MAX_RES   = 8,
    parameter int UNIT_BITS = 16
) (
    input logic          clk,
    input logic          rst_n,
    bda_stream_if.sink   item_in,
    bda_stream_if.source result_out,
    bda_stream_if.sink   cfg
);
    localparam int UB    = UNIT_BITS;
    localparam int NW    = UB + 1;
    localparam int VW    = UB + 6;
    localparam int PW    = MAX_PROCS > 1 ? $clog2(MAX_PROCS) : 1;
    localparam int RW    = MAX_RES > 1 ? $clog2(MAX_RES) : 1;
    localparam int DEPTH = MAX_PROCS * MAX_RES;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD      = 4'd1;
    localparam logic [3:0] S_EV      = 4'd2;
    localparam logic [3:0] S_INIT    = 4'd3;
    localparam logic [3:0] S_ROW     = 4'd4;
    localparam logic [3:0] S_ROWDONE = 4'd5;
    localparam logic [3:0] S_EMIT    = 4'd6;
    localparam logic [3:0] S_OUT     = 4'd7;
    localparam logic [3:0] S_ORD     = 4'd8;
    localparam logic [3:0] S_ORDEND  = 4'd9;
    localparam logic [3:0] S_REQ     = 4'd10;

    localparam logic [1:0] CTX_FIND  = 2'd0;
    localparam logic [1:0] CTX_ORDER = 2'd1;
    localparam logic [1:0] CTX_REQ   = 2'd2;

    localparam logic [2:0] OP_FIT   = 3'd0;
    localparam logic [2:0] OP_CHK   = 3'd1;
    localparam logic [2:0] OP_APPLY = 3'd2;
    localparam logic [2:0] OP_ROLL  = 3'd3;
    localparam logic [2:0] OP_WR0   = 3'd4;

    logic [3:0]               state_reg, state_next;
    logic [1:0]               ctx_reg, ctx_next;
    logic [2:0]               op_reg, op_next;
    bda_pkg::bda_item_t       item_reg;
    logic [PW:0]              pi_reg, pi_next;
    logic [RW:0]              j_reg, j_next;
    logic [PW:0]              count_reg, count_next;
    logic                     progress_reg, progress_next;
    logic                     fit_ok_reg, fit_ok_next;
    logic [MAX_PROCS-1:0]     finished_reg, finished_next;
    logic                     failed_reg, failed_next;
    logic                     order_active_reg, order_active_next;
    logic                     request_active_reg, request_active_next;
    logic [4:0]               np_reg, np_next;
    logic [3:0]               nr_reg, nr_next;
    logic signed [VW-1:0]     work_reg [MAX_RES];
    logic signed [VW-1:0]     work_next [MAX_RES];
    logic signed [VW-1:0]     tw_reg [MAX_RES];
    logic signed [VW-1:0]     tw_next [MAX_RES];
    logic signed [UB+1:0]     avail_reg [MAX_RES];
    logic signed [UB+1:0]     avail_next [MAX_RES];
    logic [UB-1:0]            total_reg [MAX_RES];
    logic [UB-1:0]            total_next [MAX_RES];
    logic [UB-1:0]            req_reg [MAX_RES];
    logic [UB-1:0]            req_next [MAX_RES];
    logic [3:0]               ord_reg [MAX_PROCS];
    logic                     ord_we;
    bda_pkg::bda_result_t     verdict_reg, verdict_next;
    bda_pkg::bda_result_t     out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic [AW-1:0]            tbl_addr;
    logic                     tbl_we;
    logic [UB+NW-1:0]         tbl_wdata;
    logic [UB+NW-1:0]         tbl_rdata;
    logic [UB-1:0]            rd_alloc;
    logic signed [NW-1:0]     rd_need;
    logic [MAX_PROCS-1:0]     all_mask;
    logic                     slot_free;
    logic                     item_acc;
    logic [7:0]               np8, nr8;

    function automatic logic signed [UB+1:0] sat_avail(input logic signed [UB+2:0] v);
        logic signed [UB+1:0] r;
        if (v[UB+2] != v[UB+1])
        begin
            r = v[UB+2] ? {1'b1, {(UB+1){1'b0}}} : {1'b0, {(UB+1){1'b1}}};
        end
        else
        begin
            r = v[UB+1:0];
        end
        return r;
    endfunction

    bda_table #(
        .DEPTH (DEPTH),
        .WIDTH (UB + NW)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .addr  (tbl_addr),
        .we    (tbl_we),
        .wdata (tbl_wdata),
        .rdata (tbl_rdata)
    );

    assign tbl_addr  = AW'(AW'(pi_reg[PW-1:0]) * AW'(MAX_RES) + AW'(j_reg[RW-1:0]));
    assign rd_alloc  = tbl_rdata[UB+NW-1:NW];
    assign rd_need   = $signed(tbl_rdata[NW-1:0]);
    assign slot_free = !out_valid_reg || result_out.ready;
    assign item_acc  = item_in.valid && item_in.ready;
    assign np8       = 8'(np_reg);
    assign nr8       = 8'(nr_reg);

    assign item_in.ready    = (state_reg == S_IDLE);
    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_reg;
    assign cfg.ready        = 1'b1;

    always_comb
    begin
        for (int b = 0; b < MAX_PROCS; b++)
        begin
            all_mask[b] = (8'(b) < np8);
        end
    end

    always_comb
    begin
        logic [RW-1:0]        jx;
        logic [RW-1:0]        rx;
        logic [UB-1:0]        amt;
        logic [UB-1:0]        claim;
        logic signed [VW-1:0] need_x;
        logic signed [VW:0]   sum;
        logic signed [UB+1:0] req_x;
        logic signed [UB+1:0] need_a;
        logic [PW:0]          cnt;
        logic                 prog;
        bda_pkg::bda_item_t   it;

        state_next          = state_reg;
        ctx_next            = ctx_reg;
        op_next             = op_reg;
        pi_next             = pi_reg;
        j_next              = j_reg;
        count_next          = count_reg;
        progress_next       = progress_reg;
        fit_ok_next         = fit_ok_reg;
        finished_next       = finished_reg;
        failed_next         = failed_reg;
        order_active_next   = order_active_reg;
        request_active_next = request_active_reg;
        np_next             = np_reg;
        nr_next             = nr_reg;
        work_next           = work_reg;
        tw_next             = tw_reg;
        avail_next          = avail_reg;
        total_next          = total_reg;
        req_next            = req_reg;
        verdict_next        = verdict_reg;
        out_next            = out_reg;
        out_valid_next      = out_valid_reg && !result_out.ready;
        ord_we              = 1'b0;
        tbl_we              = 1'b0;
        tbl_wdata           = '0;

        it     = item_in.data;
        jx     = j_reg[RW-1:0];
        rx     = RW'(it.res_id);
        amt    = UB'(it.amount);
        claim  = UB'(item_reg.max_claim);
        need_x = VW'(rd_need);
        sum    = (VW+1)'(work_reg[jx]) + $signed({1'b0, (VW)'(rd_alloc)});
        req_x  = $signed({2'b00, req_reg[jx]});
        need_a = (UB+2)'(rd_need);
        cnt    = count_reg;
        prog   = progress_reg;

        if (cfg.valid)
        begin
            if (cfg.data.index == bda_pkg::CFG_NUM_PROCS)
            begin
                if (cfg.data.value[4:0] == 5'd0)
                begin
                    np_next = 5'd1;
                end
                else if (8'(cfg.data.value[4:0]) > 8'(MAX_PROCS))
                begin
                    np_next = 5'(MAX_PROCS);
                end
                else
                begin
                    np_next = cfg.data.value[4:0];
                end
            end
            else if (cfg.data.index == bda_pkg::CFG_NUM_RES)
            begin
                if (cfg.data.value[3:0] == 4'd0)
                begin
                    nr_next = 4'd1;
                end
                else if (8'(cfg.data.value[3:0]) > 8'(MAX_RES))
                begin
                    nr_next = 4'(MAX_RES);
                end
                else
                begin
                    nr_next = cfg.data.value[3:0];
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    if (it.mode != bda_pkg::MODE_ORDER)
                    begin
                        order_active_next = 1'b0;
                    end
                    if (it.mode != bda_pkg::MODE_REQUEST)
                    begin
                        request_active_next = 1'b0;
                    end
                    case (it.mode)
                        bda_pkg::MODE_WRITE:
                        begin
                            if (8'(it.proc_id) < np8 && 8'(it.res_id) < nr8)
                            begin
                                pi_next    = (PW+1)'(it.proc_id);
                                j_next     = (RW+1)'(it.res_id);
                                op_next    = OP_WR0;
                                state_next = S_RD;
                            end
                        end
                        bda_pkg::MODE_TOTAL:
                        begin
                            if (8'(it.res_id) < nr8)
                            begin
                                total_next[rx] = amt;
                                avail_next[rx] = sat_avail((UB+3)'(avail_reg[rx])
                                    + $signed({3'b000, amt})
                                    - $signed({3'b000, total_reg[rx]}));
                            end
                        end
                        bda_pkg::MODE_FIND:
                        begin
                            ctx_next   = CTX_FIND;
                            state_next = S_INIT;
                        end
                        bda_pkg::MODE_ORDER:
                        begin
                            if (!order_active_reg)
                            begin
                                for (int k = 0; k < MAX_RES; k++)
                                begin
                                    work_next[k] = VW'(avail_reg[k]);
                                end
                                finished_next = '0;
                                failed_next   = 1'b0;
                            end
                            order_active_next = 1'b1;
                            state_next        = S_ORD;
                        end
                        bda_pkg::MODE_REQUEST:
                        begin
                            if (!request_active_reg)
                            begin
                                for (int k = 0; k < MAX_RES; k++)
                                begin
                                    req_next[k] = '0;
                                end
                            end
                            if (8'(it.res_id) < nr8)
                            begin
                                req_next[rx] = amt;
                            end
                            request_active_next = 1'b1;
                            if (it.last)
                            begin
                                request_active_next = 1'b0;
                                state_next          = S_REQ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_EV;
            end
            S_EV:
            begin
                case (op_reg)
                    OP_FIT:
                    begin
                        if (sum[VW] != sum[VW-1])
                        begin
                            tw_next[jx] = {1'b0, {(VW-1){1'b1}}};
                        end
                        else
                        begin
                            tw_next[jx] = sum[VW-1:0];
                        end
                        if (need_x > work_reg[jx])
                        begin
                            fit_ok_next = 1'b0;
                            state_next  = S_ROWDONE;
                        end
                        else if (8'(j_reg) + 8'd1 == nr8)
                        begin
                            state_next = S_ROWDONE;
                        end
                        else
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    OP_CHK:
                    begin
                        if (req_x > need_a || req_x > avail_reg[jx])
                        begin
                            verdict_next = '{bda_pkg::KIND_REQUEST, 4'd0, 1'b0, 1'b1};
                            state_next   = S_OUT;
                        end
                        else if (8'(j_reg) + 8'd1 == nr8)
                        begin
                            j_next     = '0;
                            op_next    = OP_APPLY;
                            state_next = S_RD;
                        end
                        else
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = S_RD;
                        end
                    end
                    OP_APPLY, OP_ROLL:
                    begin
                        tbl_we = 1'b1;
                        if (op_reg == OP_APPLY)
                        begin
                            tbl_wdata       = {rd_alloc + req_reg[jx],
                                               rd_need - $signed({1'b0, req_reg[jx]})};
                            avail_next[jx]  = avail_reg[jx] - req_x;
                        end
                        else
                        begin
                            tbl_wdata       = {rd_alloc - req_reg[jx],
                                               rd_need + $signed({1'b0, req_reg[jx]})};
                            avail_next[jx]  = avail_reg[jx] + req_x;
                        end
                        if (8'(j_reg) + 8'd1 != nr8)
                        begin
                            j_next     = j_reg + 1'b1;
                            state_next = S_RD;
                        end
                        else if (op_reg == OP_APPLY)
                        begin
                            ctx_next   = CTX_REQ;
                            state_next = S_INIT;
                        end
                        else
                        begin
                            verdict_next = '{bda_pkg::KIND_REQUEST, 4'd0, 1'b0, 1'b1};
                            state_next   = S_OUT;
                        end
                    end
                    OP_WR0:
                    begin
                        tbl_we         = 1'b1;
                        tbl_wdata      = {UB'(item_reg.amount),
                                          $signed({1'b0, claim})
                                          - $signed({1'b0, UB'(item_reg.amount)})};
                        avail_next[jx] = sat_avail((UB+3)'(avail_reg[jx])
                            - $signed({3'b000, UB'(item_reg.amount)})
                            + $signed({3'b000, rd_alloc}));
                        state_next     = S_IDLE;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_INIT:
            begin
                for (int k = 0; k < MAX_RES; k++)
                begin
                    work_next[k] = VW'(avail_reg[k]);
                end
                finished_next = '0;
                count_next    = '0;
                pi_next       = '0;
                progress_next = 1'b0;
                state_next    = S_ROW;
            end
            S_ROW:
            begin
                if (finished_reg[pi_reg[PW-1:0]])
                begin
                    fit_ok_next = 1'b0;
                    state_next  = S_ROWDONE;
                end
                else
                begin
                    fit_ok_next = 1'b1;
                    j_next      = '0;
                    op_next     = OP_FIT;
                    state_next  = S_RD;
                end
            end
            S_ROWDONE:
            begin
                if (fit_ok_reg)
                begin
                    work_next                      = tw_reg;
                    finished_next[pi_reg[PW-1:0]] = 1'b1;
                end
                if (ctx_reg == CTX_ORDER)
                begin
                    if (!fit_ok_reg)
                    begin
                        failed_next = 1'b1;
                    end
                    state_next = S_ORDEND;
                end
                else
                begin
                    if (fit_ok_reg)
                    begin
                        ord_we = 1'b1;
                        cnt    = count_reg + 1'b1;
                        prog   = 1'b1;
                    end
                    count_next    = cnt;
                    progress_next = prog;
                    if (8'(pi_reg) + 8'd1 != np8)
                    begin
                        pi_next    = pi_reg + 1'b1;
                        state_next = S_ROW;
                    end
                    else if (8'(cnt) == np8)
                    begin
                        if (ctx_reg == CTX_FIND)
                        begin
                            pi_next    = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            verdict_next = '{bda_pkg::KIND_REQUEST, 4'd0, 1'b1, 1'b1};
                            state_next   = S_OUT;
                        end
                    end
                    else if (!prog)
                    begin
                        if (ctx_reg == CTX_FIND)
                        begin
                            verdict_next = '{bda_pkg::KIND_ORDER, 4'd0, 1'b0, 1'b1};
                            state_next   = S_OUT;
                        end
                        else
                        begin
                            pi_next    = (PW+1)'(item_reg.proc_id);
                            j_next     = '0;
                            op_next    = OP_ROLL;
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        pi_next       = '0;
                        progress_next = 1'b0;
                        state_next    = S_ROW;
                    end
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{bda_pkg::KIND_ORDER, ord_reg[pi_reg[PW-1:0]], 1'b1,
                                       8'(pi_reg) + 8'd1 == np8};
                    pi_next        = pi_reg + 1'b1;
                    if (8'(pi_reg) + 8'd1 == np8)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = verdict_reg;
                    state_next     = S_IDLE;
                end
            end
            S_ORD:
            begin
                if (failed_reg)
                begin
                    state_next = S_ORDEND;
                end
                else if (8'(item_reg.proc_id) >= np8
                         || finished_reg[PW'(item_reg.proc_id)])
                begin
                    failed_next = 1'b1;
                    state_next  = S_ORDEND;
                end
                else
                begin
                    ctx_next    = CTX_ORDER;
                    pi_next     = (PW+1)'(item_reg.proc_id);
                    j_next      = '0;
                    fit_ok_next = 1'b1;
                    op_next     = OP_FIT;
                    state_next  = S_RD;
                end
            end
            S_ORDEND:
            begin
                if (item_reg.last)
                begin
                    order_active_next = 1'b0;
                    verdict_next      = '{bda_pkg::KIND_CHECK, 4'd0,
                                          !failed_reg && finished_reg == all_mask, 1'b1};
                    state_next        = S_OUT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REQ:
            begin
                if (8'(item_reg.proc_id) >= np8)
                begin
                    verdict_next = '{bda_pkg::KIND_REQUEST, 4'd0, 1'b0, 1'b1};
                    state_next   = S_OUT;
                end
                else
                begin
                    pi_next    = (PW+1)'(item_reg.proc_id);
                    j_next     = '0;
                    op_next    = OP_CHK;
                    state_next = S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            ctx_reg            <= CTX_FIND;
            op_reg             <= OP_FIT;
            pi_reg             <= '0;
            j_reg              <= '0;
            count_reg          <= '0;
            progress_reg       <= 1'b0;
            fit_ok_reg         <= 1'b0;
            finished_reg       <= '0;
            failed_reg         <= 1'b0;
            order_active_reg   <= 1'b0;
            request_active_reg <= 1'b0;
            np_reg             <= (MAX_PROCS < 16) ? 5'(MAX_PROCS) : 5'd16;
            nr_reg             <= (MAX_RES < 8) ? 4'(MAX_RES) : 4'd8;
            out_valid_reg      <= 1'b0;
            for (int k = 0; k < MAX_RES; k++)
            begin
                avail_reg[k] <= '0;
                total_reg[k] <= '0;
                req_reg[k]   <= '0;
            end
        end
        else
        begin
            state_reg          <= state_next;
            ctx_reg            <= ctx_next;
            op_reg             <= op_next;
            pi_reg             <= pi_next;
            j_reg              <= j_next;
            count_reg          <= count_next;
            progress_reg       <= progress_next;
            fit_ok_reg         <= fit_ok_next;
            finished_reg       <= finished_next;
            failed_reg         <= failed_next;
            order_active_reg   <= order_active_next;
            request_active_reg <= request_active_next;
            np_reg             <= np_next;
            nr_reg             <= nr_next;
            out_valid_reg      <= out_valid_next;
            avail_reg          <= avail_next;
            total_reg          <= total_next;
            req_reg            <= req_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        tw_reg      <= tw_next;
        verdict_reg <= verdict_next;
        out_reg     <= out_next;
        if (item_acc)
        begin
            item_reg <= item_in.data;
        end
        if (ord_we)
        begin
            ord_reg[count_reg[PW-1:0]] <= 4'(pi_reg);
        end
    end

    a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_EV)
        else $error("table read not followed by evaluation");

    a_emit_complete: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> 8'(count_reg) == np8)
        else $error("safe order emitted before every process finished");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW && ctx_reg != CTX_ORDER)
        |-> $countones(finished_reg) == int'(count_reg))
        else $error("finished flags disagree with the order count");
endmodule
